// ===== hdl/fbsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Face box square decoder package
// Shared widths, reset values, register indexes, stage payload types and the
// frame size saturation helper.
// ----------------------------------------------------------------------------
package fbsq_pkg;

    // Fixed point and frame geometry.
    localparam int FRAC_BITS     = 16;
    localparam int MAX_FRAME_DIM = 4096;
    localparam int MIN_SIDE      = 16;

    // Field widths.
    localparam int DIM_W   = 13;
    localparam int NORM_W  = 18;
    localparam int SCORE_W = 16;
    localparam int CNT_W   = 8;
    localparam int PIX_W   = 14;
    localparam int GEO_W   = 16;
    localparam int HALF_W  = 12;
    localparam int PROD_W  = NORM_W + DIM_W + 1;

    // Reciprocal of five with 16 fraction bits, exact for the doubled side.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_5     = 13108;

    // Square fitting widths: corner sum, four times the extent, reciprocal
    // product and the doubled extent.
    localparam int SUM_W = PIX_W + 1;
    localparam int M4_W  = GEO_W + 2;
    localparam int MUL_W = RECIP_SHIFT + HALF_W;
    localparam int TWO_W = PIX_W;

    // Configuration port.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH     = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT    = DIM_W'(480);
    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = SCORE_W'(45875);
    localparam logic [CNT_W-1:0]   RST_MAX_FACES       = CNT_W'(16);

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_SCORE_THRESHOLD = 2'd2,
        REG_MAX_FACES       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [SCORE_W-1:0] score_threshold;
        logic [CNT_W-1:0]   max_faces;
    } cfg_t;

    // Side information that travels with every box.
    typedef struct packed {
        logic             kept;
        logic [CNT_W-1:0] total;
        logic             eof;
    } meta_t;

    typedef struct packed {
        meta_t                   meta;
        logic signed [PIX_W-1:0] x1;
        logic signed [PIX_W-1:0] y1;
        logic signed [PIX_W-1:0] x2;
        logic signed [PIX_W-1:0] y2;
    } pix_t;

    typedef struct packed {
        meta_t                   meta;
        logic signed [PIX_W-1:0] cx;
        logic signed [PIX_W-1:0] cy;
        logic signed [GEO_W-1:0] m;
    } geo_t;

    typedef struct packed {
        meta_t                   meta;
        logic signed [PIX_W-1:0] cx;
        logic signed [PIX_W-1:0] cy;
        logic [HALF_W-1:0]       half;
    } half_t;

    // Frame sizes above the supported maximum saturate to it.
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        if (v > DIM_W'(MAX_FRAME_DIM)) begin
            return DIM_W'(MAX_FRAME_DIM);
        end
        return v;
    endfunction

endpackage

// ===== hdl/fbsq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding frame size, score threshold and face limit.
// ----------------------------------------------------------------------------
module fbsq_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fbsq_pkg::ADDR_W-1:0]  paddr,
    input  logic [fbsq_pkg::DATA_W-1:0]  pwdata,
    output logic [fbsq_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output fbsq_pkg::cfg_t               cfg
);

    fbsq_pkg::cfg_t     cfg_reg;
    fbsq_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = fbsq_pkg::reg_idx_t'(paddr[fbsq_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= fbsq_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height    <= fbsq_pkg::RST_FRAME_HEIGHT;
            cfg_reg.score_threshold <= fbsq_pkg::RST_SCORE_THRESHOLD;
            cfg_reg.max_faces       <= fbsq_pkg::RST_MAX_FACES;
        end
        else if (wr_en)
        begin
            unique case (idx)
                fbsq_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= pwdata[fbsq_pkg::DIM_W-1:0];
                fbsq_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= pwdata[fbsq_pkg::DIM_W-1:0];
                fbsq_pkg::REG_SCORE_THRESHOLD:
                    cfg_reg.score_threshold <= pwdata[fbsq_pkg::SCORE_W-1:0];
                fbsq_pkg::REG_MAX_FACES:
                    cfg_reg.max_faces <= pwdata[fbsq_pkg::CNT_W-1:0];
            endcase
        end
    end

    // Read back the stored value.
    always_comb
    begin
        unique case (idx)
            fbsq_pkg::REG_FRAME_WIDTH:
                prdata = fbsq_pkg::DATA_W'(cfg_reg.frame_width);
            fbsq_pkg::REG_FRAME_HEIGHT:
                prdata = fbsq_pkg::DATA_W'(cfg_reg.frame_height);
            fbsq_pkg::REG_SCORE_THRESHOLD:
                prdata = fbsq_pkg::DATA_W'(cfg_reg.score_threshold);
            fbsq_pkg::REG_MAX_FACES:
                prdata = fbsq_pkg::DATA_W'(cfg_reg.max_faces);
        endcase
    end

endmodule

// ===== hdl/fbsq_front.sv =====
// ----------------------------------------------------------------------------
// Input register, keep decision and pixel scaling
// Registers the incoming box, decides whether it is kept, updates the per
// frame counter and scales the four corners to pixels.
// ----------------------------------------------------------------------------
module fbsq_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fbsq_pkg::cfg_t                     cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [fbsq_pkg::SCORE_W-1:0]       score,
    input  logic signed [fbsq_pkg::NORM_W-1:0] x_left_norm,
    input  logic signed [fbsq_pkg::NORM_W-1:0] y_top_norm,
    input  logic signed [fbsq_pkg::NORM_W-1:0] x_right_norm,
    input  logic signed [fbsq_pkg::NORM_W-1:0] y_bottom_norm,
    input  logic                               frame_last,
    output logic                               pix_valid,
    output fbsq_pkg::pix_t                     pix,
    input  logic                               pix_ready
);

    logic                               in_v_reg;
    logic [fbsq_pkg::SCORE_W-1:0]       in_score_reg;
    logic signed [fbsq_pkg::NORM_W-1:0] in_xl_reg;
    logic signed [fbsq_pkg::NORM_W-1:0] in_yt_reg;
    logic signed [fbsq_pkg::NORM_W-1:0] in_xr_reg;
    logic signed [fbsq_pkg::NORM_W-1:0] in_yb_reg;
    logic                               in_last_reg;
    logic                               pix_v_reg;
    fbsq_pkg::pix_t                     pix_reg;
    fbsq_pkg::pix_t                     pix_next;
    logic [fbsq_pkg::CNT_W-1:0]         cnt_reg;
    logic [fbsq_pkg::CNT_W-1:0]         cnt_next;
    logic [fbsq_pkg::CNT_W-1:0]         total;
    logic [fbsq_pkg::DIM_W-1:0]         dim_w;
    logic [fbsq_pkg::DIM_W-1:0]         dim_h;
    logic                               keep;
    logic                               in_ready;
    logic                               pix_ready_int;
    logic                               adv;

    // Normalized coordinate times frame size, truncated toward zero.
    function automatic logic signed [fbsq_pkg::PIX_W-1:0] to_pixel(
        input logic signed [fbsq_pkg::NORM_W-1:0] n,
        input logic [fbsq_pkg::DIM_W-1:0]         d
    );
        logic signed [fbsq_pkg::PROD_W-1:0] p;
        p = fbsq_pkg::PROD_W'(n) * $signed({1'b0, d});
        if (p < 0)
        begin
            p = p + fbsq_pkg::PROD_W'((1 << fbsq_pkg::FRAC_BITS) - 1);
        end
        return p[fbsq_pkg::FRAC_BITS+fbsq_pkg::PIX_W-1:fbsq_pkg::FRAC_BITS];
    endfunction

    // Handshake: the input register empties whenever the pixel stage can take it.
    assign pix_ready_int = !pix_v_reg || pix_ready;
    assign adv           = in_v_reg && pix_ready_int;
    assign in_ready      = !in_v_reg || pix_ready_int;
    assign in_stall      = !in_ready;
    assign pix_valid     = pix_v_reg;
    assign pix           = pix_reg;

    // Keep decision and frame counter update.
    assign keep  = (in_score_reg > cfg.score_threshold) && (cnt_reg < cfg.max_faces);
    assign total = cnt_reg + fbsq_pkg::CNT_W'(keep);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (adv)
        begin
            cnt_next = in_last_reg ? '0 : total;
        end
    end

    // Corner scaling.
    assign dim_w = fbsq_pkg::sat_dim(cfg.frame_width);
    assign dim_h = fbsq_pkg::sat_dim(cfg.frame_height);

    always_comb
    begin
        pix_next.meta.kept  = keep;
        pix_next.meta.total = total;
        pix_next.meta.eof   = in_last_reg;
        pix_next.x1         = to_pixel(in_xl_reg, dim_w);
        pix_next.y1         = to_pixel(in_yt_reg, dim_h);
        pix_next.x2         = to_pixel(in_xr_reg, dim_w);
        pix_next.y2         = to_pixel(in_yb_reg, dim_h);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            pix_v_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_v_reg <= in_valid;
            end
            if (pix_ready_int)
            begin
                pix_v_reg <= in_v_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_score_reg <= score;
            in_xl_reg    <= x_left_norm;
            in_yt_reg    <= y_top_norm;
            in_xr_reg    <= x_right_norm;
            in_yb_reg    <= y_bottom_norm;
            in_last_reg  <= frame_last;
        end
        if (adv)
        begin
            pix_reg <= pix_next;
        end
    end

`ifndef SYNTHESIS
    // The counter starts over after the last box of a frame.
    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_last_reg) |=> (cnt_reg == '0))
        else $error("kept counter not cleared after end of frame");

    // The counter only moves when a box leaves the input register.
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cnt_reg))
        else $error("kept counter changed without a box");

    // A kept box always counts itself.
    a_total_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_v_reg && pix_reg.meta.kept) |-> (pix_reg.meta.total != '0))
        else $error("kept box with zero face total");
`endif

endmodule

// ===== hdl/fbsq_square.sv =====
// ----------------------------------------------------------------------------
// Square fitting stages
// Box geometry, half side selection and frame clamp, one register stage each,
// ending in the result register.
// ----------------------------------------------------------------------------
module fbsq_square (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fbsq_pkg::cfg_t                   cfg,
    input  logic                             pix_valid,
    input  fbsq_pkg::pix_t                   pix,
    output logic                             pix_ready,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             kept,
    output logic [fbsq_pkg::DIM_W-1:0]       sq_left,
    output logic [fbsq_pkg::DIM_W-1:0]       sq_top,
    output logic [fbsq_pkg::DIM_W-1:0]       sq_right,
    output logic [fbsq_pkg::DIM_W-1:0]       sq_bottom,
    output logic [fbsq_pkg::CNT_W-1:0]       face_total,
    output logic                             end_of_frame
);

    logic                              geo_v_reg;
    fbsq_pkg::geo_t                    geo_reg;
    fbsq_pkg::geo_t                    geo_next;
    logic                              half_v_reg;
    fbsq_pkg::half_t                   half_reg;
    fbsq_pkg::half_t                   half_next;
    logic                              res_v_reg;
    logic                              res_kept_reg;
    logic [fbsq_pkg::DIM_W-1:0]        res_left_reg;
    logic [fbsq_pkg::DIM_W-1:0]        res_top_reg;
    logic [fbsq_pkg::DIM_W-1:0]        res_right_reg;
    logic [fbsq_pkg::DIM_W-1:0]        res_bottom_reg;
    logic [fbsq_pkg::CNT_W-1:0]        res_total_reg;
    logic                              res_eof_reg;
    logic [fbsq_pkg::DIM_W-1:0]        left_next;
    logic [fbsq_pkg::DIM_W-1:0]        top_next;
    logic [fbsq_pkg::DIM_W-1:0]        right_next;
    logic [fbsq_pkg::DIM_W-1:0]        bottom_next;
    logic [fbsq_pkg::DIM_W-1:0]        dim_w;
    logic [fbsq_pkg::DIM_W-1:0]        dim_h;
    logic [fbsq_pkg::DIM_W-1:0]        dim_min;
    logic                              geo_ready;
    logic                              half_ready;
    logic                              res_ready;

    // Truncating halving of a signed sum.
    function automatic logic signed [fbsq_pkg::PIX_W-1:0] mid(
        input logic signed [fbsq_pkg::PIX_W-1:0] a,
        input logic signed [fbsq_pkg::PIX_W-1:0] b
    );
        logic signed [fbsq_pkg::SUM_W-1:0] s;
        s = fbsq_pkg::SUM_W'(a) + fbsq_pkg::SUM_W'(b);
        s = s + fbsq_pkg::SUM_W'(s[fbsq_pkg::SUM_W-1]);
        return s[fbsq_pkg::SUM_W-1:1];
    endfunction

    // Move a center so that the square lies inside [0, dim).
    function automatic logic signed [fbsq_pkg::GEO_W-1:0] clamp_center(
        input logic signed [fbsq_pkg::PIX_W-1:0] c,
        input logic [fbsq_pkg::HALF_W-1:0]       h,
        input logic [fbsq_pkg::DIM_W-1:0]        d
    );
        logic signed [fbsq_pkg::GEO_W-1:0] ce;
        logic signed [fbsq_pkg::GEO_W-1:0] he;
        logic signed [fbsq_pkg::GEO_W-1:0] de;
        ce = fbsq_pkg::GEO_W'(c);
        he = $signed(fbsq_pkg::GEO_W'(h));
        de = $signed(fbsq_pkg::GEO_W'(d));
        if (ce + he >= de)
        begin
            ce = de - he - fbsq_pkg::GEO_W'(1);
        end
        if (ce - he < 0)
        begin
            ce = he;
        end
        return ce;
    endfunction

    // Stage handshakes: each register refills when empty or when it drains.
    assign res_ready  = !res_v_reg || !out_stall;
    assign half_ready = !half_v_reg || res_ready;
    assign geo_ready  = !geo_v_reg || half_ready;
    assign pix_ready  = geo_ready;

    assign dim_w   = fbsq_pkg::sat_dim(cfg.frame_width);
    assign dim_h   = fbsq_pkg::sat_dim(cfg.frame_height);
    assign dim_min = (dim_w < dim_h) ? dim_w : dim_h;

    // Geometry: width, height, larger extent and center.
    always_comb
    begin
        logic signed [fbsq_pkg::GEO_W-1:0] bw;
        logic signed [fbsq_pkg::GEO_W-1:0] bh;
        bw = fbsq_pkg::GEO_W'(pix.x2) - fbsq_pkg::GEO_W'(pix.x1) + fbsq_pkg::GEO_W'(1);
        bh = fbsq_pkg::GEO_W'(pix.y2) - fbsq_pkg::GEO_W'(pix.y1) + fbsq_pkg::GEO_W'(1);
        geo_next.meta = pix.meta;
        geo_next.cx   = mid(pix.x1, pix.x2);
        geo_next.cy   = mid(pix.y1, pix.y2);
        geo_next.m    = (bw > bh) ? bw : bh;
    end

    // Half side: capped by the frame, floored at the minimum, else 2m/5.
    always_comb
    begin
        logic signed [fbsq_pkg::M4_W-1:0] m4;
        logic signed [fbsq_pkg::M4_W-1:0] cap5;
        logic [fbsq_pkg::TWO_W-1:0]       twom;
        logic [fbsq_pkg::MUL_W-1:0]       prod;
        m4   = fbsq_pkg::M4_W'(geo_reg.m) <<< 2;
        cap5 = $signed(fbsq_pkg::M4_W'(dim_min) + (fbsq_pkg::M4_W'(dim_min) << 2));
        twom = {geo_reg.m[fbsq_pkg::TWO_W-2:0], 1'b0};
        prod = fbsq_pkg::MUL_W'(twom) * fbsq_pkg::MUL_W'(fbsq_pkg::RECIP_5);
        half_next.meta = geo_reg.meta;
        half_next.cx   = geo_reg.cx;
        half_next.cy   = geo_reg.cy;
        priority if (m4 > cap5)
        begin
            if (dim_min < fbsq_pkg::DIM_W'(fbsq_pkg::MIN_SIDE))
            begin
                half_next.half = fbsq_pkg::HALF_W'(fbsq_pkg::MIN_SIDE / 2);
            end
            else
            begin
                half_next.half = dim_min[fbsq_pkg::DIM_W-1:1];
            end
        end
        else if (m4 < fbsq_pkg::M4_W'(5 * fbsq_pkg::MIN_SIDE))
        begin
            half_next.half = fbsq_pkg::HALF_W'(fbsq_pkg::MIN_SIDE / 2);
        end
        else
        begin
            half_next.half = prod[fbsq_pkg::MUL_W-1:fbsq_pkg::RECIP_SHIFT];
        end
    end

    // Frame clamp and corner output; dropped boxes give zero corners.
    always_comb
    begin
        logic signed [fbsq_pkg::GEO_W-1:0] cxc;
        logic signed [fbsq_pkg::GEO_W-1:0] cyc;
        logic signed [fbsq_pkg::GEO_W-1:0] he;
        logic signed [fbsq_pkg::GEO_W-1:0] l;
        logic signed [fbsq_pkg::GEO_W-1:0] t;
        logic signed [fbsq_pkg::GEO_W-1:0] r;
        logic signed [fbsq_pkg::GEO_W-1:0] b;
        cxc = clamp_center(half_reg.cx, half_reg.half, dim_w);
        cyc = clamp_center(half_reg.cy, half_reg.half, dim_h);
        he  = $signed(fbsq_pkg::GEO_W'(half_reg.half));
        l   = cxc - he;
        t   = cyc - he;
        r   = cxc + he;
        b   = cyc + he;
        if (half_reg.meta.kept)
        begin
            left_next   = l[fbsq_pkg::DIM_W-1:0];
            top_next    = t[fbsq_pkg::DIM_W-1:0];
            right_next  = r[fbsq_pkg::DIM_W-1:0];
            bottom_next = b[fbsq_pkg::DIM_W-1:0];
        end
        else
        begin
            left_next   = '0;
            top_next    = '0;
            right_next  = '0;
            bottom_next = '0;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_v_reg  <= 1'b0;
            half_v_reg <= 1'b0;
            res_v_reg  <= 1'b0;
        end
        else
        begin
            if (geo_ready)
            begin
                geo_v_reg <= pix_valid;
            end
            if (half_ready)
            begin
                half_v_reg <= geo_v_reg;
            end
            if (res_ready)
            begin
                res_v_reg <= half_v_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (geo_ready && pix_valid)
        begin
            geo_reg <= geo_next;
        end
        if (half_ready && geo_v_reg)
        begin
            half_reg <= half_next;
        end
        if (res_ready && half_v_reg)
        begin
            res_kept_reg   <= half_reg.meta.kept;
            res_left_reg   <= left_next;
            res_top_reg    <= top_next;
            res_right_reg  <= right_next;
            res_bottom_reg <= bottom_next;
            res_total_reg  <= half_reg.meta.total;
            res_eof_reg    <= half_reg.meta.eof;
        end
    end

    assign out_valid    = res_v_reg;
    assign kept         = res_kept_reg;
    assign sq_left      = res_left_reg;
    assign sq_top       = res_top_reg;
    assign sq_right     = res_right_reg;
    assign sq_bottom    = res_bottom_reg;
    assign face_total   = res_total_reg;
    assign end_of_frame = res_eof_reg;

`ifndef SYNTHESIS
    // A dropped box carries no square.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && !res_kept_reg) |->
            (res_left_reg == '0 && res_top_reg == '0 &&
             res_right_reg == '0 && res_bottom_reg == '0))
        else $error("dropped box with nonzero corners");

    // The side of a kept square is twice the half side, so always even.
    a_side_even: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && res_kept_reg) |-> (res_right_reg[0] == res_left_reg[0]))
        else $error("square side is odd");

    // Width and height of a kept square agree.
    a_square: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && res_kept_reg) |->
            ((res_right_reg - res_left_reg) == (res_bottom_reg - res_top_reg)))
        else $error("result is not square");
`endif

endmodule

// ===== hdl/face_box_square_decoder.sv =====
// Throughput: one box per cycle while out_stall is low; every box gives
// exactly one result.
// Five register stages (input, pixel scaling, geometry, half side, result)
// stall together from the output backward, one slot per stage.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the
// per frame kept counter and loads the default configuration.
// ----------------------------------------------------------------------------
// Face box square decoder
// Filters detector boxes by score and per frame count, scales them to pixels
// and turns each kept box into a square clamped into the frame.
// ----------------------------------------------------------------------------
module face_box_square_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fbsq_pkg::ADDR_W-1:0]        paddr,
    input  logic [fbsq_pkg::DATA_W-1:0]        pwdata,
    output logic [fbsq_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [fbsq_pkg::SCORE_W-1:0]       score,
    input  logic signed [fbsq_pkg::NORM_W-1:0] x_left_norm,
    input  logic signed [fbsq_pkg::NORM_W-1:0] y_top_norm,
    input  logic signed [fbsq_pkg::NORM_W-1:0] x_right_norm,
    input  logic signed [fbsq_pkg::NORM_W-1:0] y_bottom_norm,
    input  logic                               frame_last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               kept,
    output logic [fbsq_pkg::DIM_W-1:0]         sq_left,
    output logic [fbsq_pkg::DIM_W-1:0]         sq_top,
    output logic [fbsq_pkg::DIM_W-1:0]         sq_right,
    output logic [fbsq_pkg::DIM_W-1:0]         sq_bottom,
    output logic [fbsq_pkg::CNT_W-1:0]         face_total,
    output logic                               end_of_frame
);

    fbsq_pkg::cfg_t cfg;
    fbsq_pkg::pix_t pix;
    logic           pix_valid;
    logic           pix_ready;

    // Configuration registers.
    fbsq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register, keep decision and pixel scaling.
    fbsq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .score         (score),
        .x_left_norm   (x_left_norm),
        .y_top_norm    (y_top_norm),
        .x_right_norm  (x_right_norm),
        .y_bottom_norm (y_bottom_norm),
        .frame_last    (frame_last),
        .pix_valid     (pix_valid),
        .pix           (pix),
        .pix_ready     (pix_ready)
    );

    // Square fitting and result register.
    fbsq_square u_square (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pix_valid    (pix_valid),
        .pix          (pix),
        .pix_ready    (pix_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kept         (kept),
        .sq_left      (sq_left),
        .sq_top       (sq_top),
        .sq_right     (sq_right),
        .sq_bottom    (sq_bottom),
        .face_total   (face_total),
        .end_of_frame (end_of_frame)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Face box square decoder testbench
// Streams detector boxes through the decoder under several frame sizes,
// thresholds and face limits, with random idle cycles on both channels and
// one long output hold-off. Each box accepted at the input is scored by a
// local square predictor. Every result is checked field by field against the
// oldest predicted square.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_OFF_LEN   = 80;

    // One detector box as it is offered to the decoder.
    typedef struct packed {
        logic [fbsq_pkg::SCORE_W-1:0]       score;
        logic signed [fbsq_pkg::NORM_W-1:0] xl;
        logic signed [fbsq_pkg::NORM_W-1:0] yt;
        logic signed [fbsq_pkg::NORM_W-1:0] xr;
        logic signed [fbsq_pkg::NORM_W-1:0] yb;
        logic                               last;
    } face_box_t;

    // One square as the decoder should report it.
    typedef struct packed {
        logic                       kept;
        logic [fbsq_pkg::DIM_W-1:0] left;
        logic [fbsq_pkg::DIM_W-1:0] top;
        logic [fbsq_pkg::DIM_W-1:0] right;
        logic [fbsq_pkg::DIM_W-1:0] bottom;
        logic [fbsq_pkg::CNT_W-1:0] total;
        logic                       eof;
    } square_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [fbsq_pkg::ADDR_W-1:0]   paddr = '0;
    logic [fbsq_pkg::DATA_W-1:0]   pwdata = '0;
    logic [fbsq_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [fbsq_pkg::SCORE_W-1:0]       score = '0;
    logic signed [fbsq_pkg::NORM_W-1:0] x_left_norm = '0;
    logic signed [fbsq_pkg::NORM_W-1:0] y_top_norm = '0;
    logic signed [fbsq_pkg::NORM_W-1:0] x_right_norm = '0;
    logic signed [fbsq_pkg::NORM_W-1:0] y_bottom_norm = '0;
    logic                               frame_last = 1'b0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               kept;
    logic [fbsq_pkg::DIM_W-1:0]         sq_left;
    logic [fbsq_pkg::DIM_W-1:0]         sq_top;
    logic [fbsq_pkg::DIM_W-1:0]         sq_right;
    logic [fbsq_pkg::DIM_W-1:0]         sq_bottom;
    logic [fbsq_pkg::CNT_W-1:0]         face_total;
    logic                               end_of_frame;

    // Predictor copy of the configuration and the per frame counter.
    logic [fbsq_pkg::DIM_W-1:0]   cfg_width = fbsq_pkg::RST_FRAME_WIDTH;
    logic [fbsq_pkg::DIM_W-1:0]   cfg_height = fbsq_pkg::RST_FRAME_HEIGHT;
    logic [fbsq_pkg::SCORE_W-1:0] cfg_thresh = fbsq_pkg::RST_SCORE_THRESHOLD;
    logic [fbsq_pkg::CNT_W-1:0]   cfg_max_faces = fbsq_pkg::RST_MAX_FACES;
    logic [fbsq_pkg::CNT_W-1:0]   kept_count = '0;

    face_box_t pending_boxes[$];
    square_t   expected_squares[$];
    square_t   oldest_square;

    int   mismatches = 0;
    int   send_idle_pct = 8;
    int   recv_idle_pct = 83;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    logic hold_start = 1'b0;
    logic hold_done = 1'b0;
    logic in_took = 1'b0;

    face_box_square_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .score         (score),
        .x_left_norm   (x_left_norm),
        .y_top_norm    (y_top_norm),
        .x_right_norm  (x_right_norm),
        .y_bottom_norm (y_bottom_norm),
        .frame_last    (frame_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kept          (kept),
        .sq_left       (sq_left),
        .sq_top        (sq_top),
        .sq_right      (sq_right),
        .sq_bottom     (sq_bottom),
        .face_total    (face_total),
        .end_of_frame  (end_of_frame)
    );

    always #5 clk = ~clk;

    // Works out the square for one box and advances the per frame counter.
    function automatic square_t square_box(face_box_t bx);
        square_t sq;
        longint  fw, fh, x1, y1, x2, y2, cx, cy, m, span, half, unit;
        sq = '0;
        sq.eof = bx.last;
        if (bx.score > cfg_thresh && kept_count < cfg_max_faces)
        begin
            unit = longint'(1) << fbsq_pkg::FRAC_BITS;
            fw = (cfg_width > fbsq_pkg::MAX_FRAME_DIM) ? fbsq_pkg::MAX_FRAME_DIM : cfg_width;
            fh = (cfg_height > fbsq_pkg::MAX_FRAME_DIM) ? fbsq_pkg::MAX_FRAME_DIM : cfg_height;
            x1 = (longint'($signed(bx.xl)) * fw) / unit;
            y1 = (longint'($signed(bx.yt)) * fh) / unit;
            x2 = (longint'($signed(bx.xr)) * fw) / unit;
            y2 = (longint'($signed(bx.yb)) * fh) / unit;
            cx = (x1 + x2) / 2;
            cy = (y1 + y2) / 2;
            m = x2 - x1 + 1;
            if (y2 - y1 + 1 > m)
            begin
                m = y2 - y1 + 1;
            end
            span = (fw < fh) ? fw : fh;

            // A side of 0.8 m, capped at the short frame edge, at least 16.
            if (4 * m > 5 * span)
            begin
                half = (span < fbsq_pkg::MIN_SIDE) ? fbsq_pkg::MIN_SIDE / 2 : span / 2;
            end
            else if (4 * m < 5 * fbsq_pkg::MIN_SIDE)
            begin
                half = fbsq_pkg::MIN_SIDE / 2;
            end
            else
            begin
                half = (2 * m) / 5;
            end

            // Pull the square back inside the frame, the far edge first.
            if (cx + half >= fw)
            begin
                cx = fw - half - 1;
            end
            if (cx - half < 0)
            begin
                cx = half;
            end
            if (cy + half >= fh)
            begin
                cy = fh - half - 1;
            end
            if (cy - half < 0)
            begin
                cy = half;
            end

            sq.kept = 1'b1;
            sq.left = fbsq_pkg::DIM_W'(cx - half);
            sq.top = fbsq_pkg::DIM_W'(cy - half);
            sq.right = fbsq_pkg::DIM_W'(cx + half);
            sq.bottom = fbsq_pkg::DIM_W'(cy + half);
            kept_count = kept_count + 1'b1;
        end
        sq.total = kept_count;
        if (bx.last)
        begin
            kept_count = '0;
        end
        return sq;
    endfunction

    // Mostly plausible boxes above the threshold, some off-frame, some noise.
    function automatic face_box_t random_box();
        face_box_t bx;
        int        kind, a, b, size;
        kind = $urandom_range(99, 0);
        bx.last = ($urandom_range(9, 0) == 0);
        if (kind < 70)
        begin
            if (cfg_thresh < 16'hFFFF && $urandom_range(9, 0) != 0)
            begin
                bx.score = fbsq_pkg::SCORE_W'($urandom_range(65535, int'(cfg_thresh) + 1));
            end
            else
            begin
                bx.score = fbsq_pkg::SCORE_W'($urandom_range(65535, 0));
            end
            a = $urandom_range(65536, 0);
            size = ($urandom_range(99, 0) < 80) ? $urandom_range(16384, 0)
                                                : $urandom_range(65536, 0);
            bx.xl = fbsq_pkg::NORM_W'(a);
            bx.xr = fbsq_pkg::NORM_W'((a + size > 131071) ? 131071 : a + size);
            b = $urandom_range(65536, 0);
            size = ($urandom_range(99, 0) < 80) ? $urandom_range(16384, 0)
                                                : $urandom_range(65536, 0);
            bx.yt = fbsq_pkg::NORM_W'(b);
            bx.yb = fbsq_pkg::NORM_W'((b + size > 131071) ? 131071 : b + size);
        end
        else if (kind < 85)
        begin
            bx.score = fbsq_pkg::SCORE_W'($urandom_range(65535, 0));
            bx.xl = fbsq_pkg::NORM_W'(int'($urandom_range(98304, 0)) - 32768);
            bx.yt = fbsq_pkg::NORM_W'(int'($urandom_range(98304, 0)) - 32768);
            bx.xr = fbsq_pkg::NORM_W'(int'($urandom_range(98304, 0)) - 32768);
            bx.yb = fbsq_pkg::NORM_W'(int'($urandom_range(98304, 0)) - 32768);
        end
        else
        begin
            bx.score = fbsq_pkg::SCORE_W'($urandom);
            bx.xl = fbsq_pkg::NORM_W'($urandom);
            bx.yt = fbsq_pkg::NORM_W'($urandom);
            bx.xr = fbsq_pkg::NORM_W'($urandom);
            bx.yb = fbsq_pkg::NORM_W'($urandom);
        end
        return bx;
    endfunction

    task automatic add_box(int sc, int xl, int yt, int xr, int yb, bit last);
        face_box_t bx;
        bx.score = fbsq_pkg::SCORE_W'(sc);
        bx.xl = fbsq_pkg::NORM_W'(xl);
        bx.yt = fbsq_pkg::NORM_W'(yt);
        bx.xr = fbsq_pkg::NORM_W'(xr);
        bx.yb = fbsq_pkg::NORM_W'(yb);
        bx.last = last;
        pending_boxes = {pending_boxes, bx};
    endtask

    task automatic add_random_boxes(int count);
        repeat (count)
        begin
            pending_boxes = {pending_boxes, random_box()};
        end
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(fbsq_pkg::reg_idx_t idx, int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= fbsq_pkg::DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fbsq_pkg::REG_FRAME_WIDTH:     cfg_width = fbsq_pkg::DIM_W'(value);
            fbsq_pkg::REG_FRAME_HEIGHT:    cfg_height = fbsq_pkg::DIM_W'(value);
            fbsq_pkg::REG_SCORE_THRESHOLD: cfg_thresh = fbsq_pkg::SCORE_W'(value);
            fbsq_pkg::REG_MAX_FACES:       cfg_max_faces = fbsq_pkg::CNT_W'(value);
            default: ;
        endcase
    endtask

    task automatic write_config(int fw, int fh, int thr, int max_faces);
        write_reg(fbsq_pkg::REG_FRAME_WIDTH, fw);
        write_reg(fbsq_pkg::REG_FRAME_HEIGHT, fh);
        write_reg(fbsq_pkg::REG_SCORE_THRESHOLD, thr);
        write_reg(fbsq_pkg::REG_MAX_FACES, max_faces);
    endtask

    // Waits until every box has gone in and every square has come out.
    task automatic wait_drained();
        while (pending_boxes.size() != 0 || expected_squares.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Input transfer bookkeeping: the accepted box is predicted at once.
    always @(posedge clk)
    begin
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
        begin
            expected_squares = {expected_squares, square_box(pending_boxes.pop_front())};
        end
    end

    // Box driver: holds a stalled box, otherwise offers the next or idles.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending_boxes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                score <= pending_boxes[0].score;
                x_left_norm <= pending_boxes[0].xl;
                y_top_norm <= pending_boxes[0].yt;
                x_right_norm <= pending_boxes[0].xr;
                y_bottom_norm <= pending_boxes[0].yb;
                frame_last <= pending_boxes[0].last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or one long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_start && !hold_done)
        begin
            hold_left = HOLD_OFF_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Result monitor: each output transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_squares.size() == 0)
            begin
                $error("result transfer with no box outstanding");
                mismatches++;
            end
            else
            begin
                oldest_square = expected_squares.pop_front();
                check_field("kept", int'(oldest_square.kept), int'(kept));
                check_field("sq_left", int'(oldest_square.left), int'(sq_left));
                check_field("sq_top", int'(oldest_square.top), int'(sq_top));
                check_field("sq_right", int'(oldest_square.right), int'(sq_right));
                check_field("sq_bottom", int'(oldest_square.bottom), int'(sq_bottom));
                check_field("face_total", int'(oldest_square.total), int'(face_total));
                check_field("end_of_frame", int'(oldest_square.eof), int'(end_of_frame));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed boxes at the reset configuration (640 x 480).
        add_box(45875, 0, 0, 65536, 65536, 0);          // score equal: dropped
        add_box(45876, 0, 0, 65536, 65536, 0);          // capped side
        add_box(65535, 32768, 32768, 32768, 32768, 0);  // single point: floor
        add_box(65535, 50000, 50000, 10000, 10000, 0);  // inverted box
        add_box(0, 131071, 131071, 131071, 131071, 0);  // dropped, max corners
        add_box(65535, -131072, -131072, -131072, -131072, 0);
        add_box(65535, 131071, 131071, 131071, 131071, 0);
        add_box(65535, -131072, -131072, 131071, 131071, 0);
        add_box(50000, 16384, 16384, 32768, 40000, 0);  // plain 0.8 side
        add_box(60000, 60000, 0, 65535, 8000, 0);       // near the right and top edges
        add_box(60000, 0, 20000, 61338, 30000, 0);      // side exactly at the cap
        add_box(60000, 0, 20000, 1946, 20500, 0);       // side exactly 16
        add_box(43690, 1000, 1000, 9000, 9000, 0);
        add_box(21845, 1000, 1000, 9000, 9000, 1);      // frame end
        add_box(65535, 20000, 20000, 30000, 30000, 1);  // one box frame
        add_box(60000, 30000, 10000, 40000, 50000, 0);

        // Random boxes, with a long output hold-off so the pipeline backs up.
        add_random_boxes(250);
        hold_start = 1'b1;
        wait_drained();

        // Largest frame, threshold zero, the highest face limit.
        write_config(4096, 4096, 0, 255);
        add_random_boxes(250);
        wait_drained();

        // One pixel wide frame, height saturating, nothing above threshold.
        write_config(1, 8191, 65535, 1);
        add_random_boxes(60);
        wait_drained();
        write_reg(fbsq_pkg::REG_SCORE_THRESHOLD, 65534);
        add_random_boxes(90);
        wait_drained();

        // Sender idles often, receiver seldom.
        send_idle_pct = 83;
        recv_idle_pct = 8;

        // Zero frame size, first with no faces allowed.
        write_config(0, 0, 100, 0);
        add_random_boxes(60);
        wait_drained();
        write_reg(fbsq_pkg::REG_MAX_FACES, 3);
        add_random_boxes(100);
        wait_drained();

        // Frame of minimum square size.
        write_config(16, 16, 32768, 4);
        add_random_boxes(200);
        wait_drained();

        // No idling, random settings.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4)
        begin
            write_config($urandom_range(4200, 1), $urandom_range(4200, 1),
                         $urandom_range(65535, 0), $urandom_range(255, 1));
            add_random_boxes(200);
            wait_drained();
        end

        if (mismatches == 0 && expected_squares.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fbsq_pkg.sv
hdl/fbsq_cfg_regs.sv
hdl/fbsq_front.sv
hdl/fbsq_square.sv
hdl/face_box_square_decoder.sv
tb/testbench.sv
